// File: rtl/fpt_pkg.sv
package fpt_pkg;

  localparam int MAX_FENCES_DEF = 1024;
  localparam int KEY_WIDTH_DEF  = 32;

  localparam int IS_W   = 13;
  localparam int TB_W   = 10;
  localparam int SIZE_W = 23;
  localparam int OFF_W  = 32;

  localparam logic [IS_W-1:0] INTERVAL_RST = 13'd16;
  localparam logic [TB_W-1:0] TUPLE_RST    = 10'd16;

  localparam int ADDR_W = 3;
  localparam logic REG_INTERVAL = 1'b0;
  localparam logic REG_TUPLE    = 1'b1;

  localparam logic [1:0] OP_SETUP  = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  localparam logic STATUS_HIT  = 1'b0;
  localparam logic STATUS_MISS = 1'b1;

  typedef enum logic [1:0] {
    KIND_SETUP,
    KIND_CLEAR,
    KIND_LOOKUP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    logic  last;
  } cmd_ctrl_t;

endpackage

// File: rtl/fence_pointer_table.sv
// Fence-pointer table for one sorted run. Setup transfers (op 0) carry sorted keys that are
// grouped into fences of interval_size tuples, a key with tlast closing the group and the run;
// clear (op 1) empties the table and the overflow flag; lookup (op 2) returns one result,
// op 3 is dropped. A queue in front of the execution unit takes transfers while it works, so
// the input stalls only when the queue is full. Setup and clear complete in the idle state; a
// lookup scans the fence max-key memory down from the last fence one entry per cycle, reads
// the hit fence's location in a fetch state, and holds the execution unit until it emits the
// result; an empty table goes straight to emit. Results sit in an output register, and
// the unit keeps running setup and clear while a result waits.
module fence_pointer_table import fpt_pkg::*; #(
  parameter int MAX_FENCES = MAX_FENCES_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  input  logic [((KEY_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,  // key
  input  logic [1:0]                             s_tuser,  // op
  input  logic                                   s_tlast,  // last_tuple
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  // start_offset, end_offset, table_min, table_max, overflow
  output logic [((2 * OFF_W + 2 * KEY_WIDTH + 1 + 7) / 8) * 8 - 1:0] m_tdata,
  output logic [0:0]                             m_tuser,  // status
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [ADDR_W-1:0]                      paddr,
  input  logic [31:0]                            pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int OUT_TW = ((2 * OFF_W + 2 * KEY_WIDTH + 1 + 7) / 8) * 8;

  logic [IS_W-1:0]      interval_size;
  logic [TB_W-1:0]      tuple_bytes;
  logic [SIZE_W-1:0]    stride;
  logic                 cfg_wr;
  logic                 cmd_valid;
  logic                 cmd_ready;
  cmd_ctrl_t            cmd_ctrl;
  logic [KEY_WIDTH-1:0] cmd_key;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[2])
      REG_INTERVAL: prdata = 32'(interval_size);
      REG_TUPLE:    prdata = 32'(tuple_bytes);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    stride <= SIZE_W'(interval_size) * SIZE_W'(tuple_bytes);
    if (rst) begin
      interval_size <= INTERVAL_RST;
      tuple_bytes   <= TUPLE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_INTERVAL) begin
        interval_size <= pwdata[IS_W-1:0];
      end else begin
        tuple_bytes <= pwdata[TB_W-1:0];
      end
    end
  end

  fpt_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser),
    .in_key    (s_tdata[KEY_WIDTH-1:0]),
    .in_last   (s_tlast),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd_ctrl  (cmd_ctrl),
    .cmd_key   (cmd_key)
  );

  fpt_back #(
    .MAX_FENCES (MAX_FENCES),
    .KEY_WIDTH  (KEY_WIDTH),
    .OUT_TW     (OUT_TW)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd_ctrl      (cmd_ctrl),
    .cmd_key       (cmd_key),
    .interval_size (interval_size),
    .tuple_bytes   (tuple_bytes),
    .stride        (stride),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser)
  );

endmodule

// File: rtl/fpt_ram.sv
module fpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/fpt_front.sv
module fpt_front import fpt_pkg::*; #(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_op,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic                 in_last,
  output logic                 cmd_valid,
  input  logic                 cmd_ready,
  output cmd_ctrl_t            cmd_ctrl,
  output logic [KEY_WIDTH-1:0] cmd_key
);

  localparam int QD  = 4;
  localparam int QAW = $clog2(QD);

  cmd_ctrl_t            q_ctrl [QD];
  logic [KEY_WIDTH-1:0] q_key  [QD];
  logic [QAW-1:0]       wr_ptr;
  logic [QAW-1:0]       rd_ptr;
  logic [QAW:0]         fill;
  cmd_ctrl_t            new_ctrl;
  logic                 op_ok;
  logic                 push;
  logic                 pop;

  // classify the incoming op, unused codes are dropped here
  always_comb begin
    new_ctrl.last = in_last;
    new_ctrl.kind = KIND_SETUP;
    op_ok         = 1'b1;
    unique case (in_op)
      OP_SETUP:  new_ctrl.kind = KIND_SETUP;
      OP_CLEAR:  new_ctrl.kind = KIND_CLEAR;
      OP_LOOKUP: new_ctrl.kind = KIND_LOOKUP;
      default:   op_ok         = 1'b0;
    endcase
  end

  assign in_ready  = (fill != (QAW+1)'(QD));
  assign push      = in_valid && in_ready && op_ok;
  assign cmd_valid = (fill != '0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd_ctrl  = q_ctrl[rd_ptr];
  assign cmd_key   = q_key[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_ctrl[wr_ptr] <= new_ctrl;
      q_key[wr_ptr]  <= in_key;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QAW+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QAW+1)'(1);
      end
    end
  end

endmodule

// File: rtl/fpt_back.sv
module fpt_back import fpt_pkg::*; #(
  parameter int MAX_FENCES = MAX_FENCES_DEF,
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
  parameter int OUT_TW     = 136
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_ctrl_t            cmd_ctrl,
  input  logic [KEY_WIDTH-1:0] cmd_key,
  input  logic [IS_W-1:0]      interval_size,
  input  logic [TB_W-1:0]      tuple_bytes,
  input  logic [SIZE_W-1:0]    stride,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_TW-1:0]    m_tdata,
  output logic [0:0]           m_tuser
);

  localparam int CW    = $clog2(MAX_FENCES + 1);
  localparam int AW    = MAX_FENCES > 1 ? $clog2(MAX_FENCES) : 1;
  localparam int LOC_W = OFF_W + SIZE_W;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    FETCH,
    EMIT
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic [IS_W-1:0]       fill;
  logic [KEY_WIDTH-1:0]  first_key;
  logic [OFF_W-1:0]      run_offset;
  logic                  overflow_flag;
  logic [KEY_WIDTH-1:0]  tmin;
  logic [KEY_WIDTH-1:0]  tmax;
  logic [CW-1:0]         idx;
  logic [KEY_WIDTH-1:0]  look_key;
  logic                  res_status;
  logic [OFF_W-1:0]      res_start;
  logic [OFF_W-1:0]      res_end;

  logic                  full;
  logic [IS_W-1:0]       fill_inc;
  logic                  closes;
  logic [KEY_WIDTH-1:0]  grp_min;
  logic [SIZE_W-1:0]     fence_bytes;
  logic                  wr_en;
  logic [KEY_WIDTH-1:0]  max_rdata;
  logic [LOC_W-1:0]      loc_rdata;
  logic [LOC_W-1:0]      loc_wdata;
  logic                  ge;
  logic                  scan_stop;
  logic [CW-1:0]         stop_idx;
  logic [CW-1:0]         count_m1;
  logic [CW-1:0]         idx_m1;
  logic [CW-1:0]         idx_m2;
  logic [AW-1:0]         max_raddr;
  logic [AW-1:0]         loc_raddr;
  logic                  out_free;
  logic [KEY_WIDTH-1:0]  tmin_o;
  logic [KEY_WIDTH-1:0]  tmax_o;

  assign cmd_ready   = (state == IDLE);
  assign full        = (count == CW'(MAX_FENCES));
  assign fill_inc    = fill + IS_W'(1);
  assign closes      = (fill_inc >= interval_size) || cmd_ctrl.last;
  assign grp_min     = (fill == '0) ? cmd_key : first_key;
  assign fence_bytes = SIZE_W'(fill_inc) * SIZE_W'(tuple_bytes);
  assign wr_en       = (state == IDLE) && cmd_valid && (cmd_ctrl.kind == KIND_SETUP)
                       && !full && closes;
  assign loc_wdata   = {run_offset, fence_bytes};

  assign count_m1  = count - CW'(1);
  assign idx_m1    = idx - CW'(1);
  assign idx_m2    = idx - CW'(2);
  assign ge        = $signed(max_rdata) >= $signed(look_key);
  assign stop_idx  = ge ? idx_m1 : idx;
  assign scan_stop = !ge || (idx == CW'(1));
  assign max_raddr = (state == IDLE) ? count_m1[AW-1:0] : idx_m2[AW-1:0];
  assign loc_raddr = stop_idx[AW-1:0];
  assign out_free  = !m_tvalid || m_tready;
  assign tmin_o    = (count == '0) ? '0 : tmin;
  assign tmax_o    = (count == '0) ? '0 : tmax;

  fpt_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (MAX_FENCES)
  ) u_max_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (cmd_key),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  // fence start offset and byte size
  fpt_ram #(
    .WIDTH (LOC_W),
    .DEPTH (MAX_FENCES)
  ) u_loc_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (loc_wdata),
    .raddr (loc_raddr),
    .rdata (loc_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= IDLE;
      count         <= '0;
      fill          <= '0;
      first_key     <= '0;
      run_offset    <= '0;
      overflow_flag <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != EMIT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (cmd_valid) begin
            unique case (cmd_ctrl.kind)
              KIND_SETUP: begin
                if (full) begin
                  overflow_flag <= 1'b1;
                  if (cmd_ctrl.last) begin
                    fill       <= '0;
                    run_offset <= '0;
                  end
                end else begin
                  if (fill == '0) begin
                    first_key <= cmd_key;
                  end
                  if (closes) begin
                    count <= count + CW'(1);
                    fill  <= '0;
                    tmax  <= cmd_key;
                    if (count == '0) begin
                      tmin <= grp_min;
                    end
                    if (cmd_ctrl.last) begin
                      run_offset <= '0;
                    end else begin
                      run_offset <= run_offset + OFF_W'(stride);
                    end
                  end else begin
                    fill <= fill_inc;
                  end
                end
              end
              KIND_CLEAR: begin
                count         <= '0;
                fill          <= '0;
                first_key     <= '0;
                run_offset    <= '0;
                overflow_flag <= 1'b0;
              end
              KIND_LOOKUP: begin
                look_key <= cmd_key;
                idx      <= count;
                if (count == '0) begin
                  res_status <= STATUS_MISS;
                  res_start  <= '0;
                  res_end    <= '0;
                  state      <= EMIT;
                end else begin
                  state <= SCAN;
                end
              end
              default: begin
                state <= IDLE;
              end
            endcase
          end
        end
        SCAN: begin
          if (scan_stop) begin
            idx <= stop_idx;
            if (stop_idx < count) begin
              state <= FETCH;
            end else begin
              res_status <= STATUS_MISS;
              res_start  <= '0;
              res_end    <= '0;
              state      <= EMIT;
            end
          end else begin
            idx <= idx_m1;
          end
        end
        FETCH: begin
          res_status <= STATUS_HIT;
          res_start  <= loc_rdata[LOC_W-1:SIZE_W];
          res_end    <= loc_rdata[LOC_W-1:SIZE_W] + OFF_W'(loc_rdata[SIZE_W-1:0]);
          state      <= EMIT;
        end
        EMIT: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_TW'({overflow_flag, tmax_o, tmin_o, res_end, res_start});
            m_tuser  <= res_status;
            state    <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule
